// ===== rtl/mvpmwo_pkg.sv =====
package mvpmwo_pkg;

  // Field widths
  localparam int VOICE_W    = 3;
  localparam int PHASE_W    = 26;
  localparam int FRAC_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int TBL_AW     = 10;
  localparam int TABLE_SIZE = 1024;
  localparam int RATIO_SH   = 12;

  // Default voice count for the top level
  localparam int VOICES_DEF = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_RATIO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_GAIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SCALE = 2'd3;

  localparam logic [GAIN_W-1:0] RATIO_RESET = 16'd4096;

  // Input word opcodes
  localparam logic OP_STEP = 1'b0;
  localparam logic OP_TWR  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PHASE,
    S_MUL1,
    S_MUL2,
    S_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // take a step word, register the increment
    logic tbl_wr;    // store a table word
    logic phase_upd; // update phase, read the table
    logic mul1;      // entry times depth gain
    logic mul2;      // times depth scale
    logic emit;      // load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic step_req;  // input word is a step for a voice that exists
    logic tbl_req;   // input word is a table write
    logic out_full;  // output register still holds an untaken word
  } status_t;

endpackage

// ===== rtl/mvpmwo_ctrl.sv =====
module mvpmwo_ctrl
  import mvpmwo_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  logic idle;
  assign idle = (state_r == S_IDLE);

  // Advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && status.step_req) begin
          state_nxt = S_PHASE;
        end
      end
      S_PHASE: state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_OUT;
      S_OUT: begin
        if (!status.out_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd           = '0;
    cmd.capture   = idle && in_valid && status.step_req;
    cmd.tbl_wr    = idle && in_valid && status.tbl_req;
    cmd.phase_upd = (state_r == S_PHASE);
    cmd.mul1      = (state_r == S_MUL1);
    cmd.mul2      = (state_r == S_MUL2);
    cmd.emit      = (state_r == S_OUT) && !status.out_full;
  end

  // Take input words only between steps
  assign in_stall = !idle;

endmodule

// ===== rtl/mvpmwo_dp.sv =====
module mvpmwo_dp
  import mvpmwo_pkg::*;
#(
  parameter int VOICES = VOICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cmd_t                         cmd,
  output status_t                      status,
  input  logic                         in_opcode,
  input  logic        [VOICE_W-1:0]    in_voice,
  input  logic        [PHASE_W-1:0]    in_increment,
  input  logic        [TBL_AW-1:0]     in_table_addr,
  input  logic signed [SAMPLE_W-1:0]   in_table_data,
  input  logic                         cfg_wr,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [SAMPLE_W-1:0]   out_sample,
  output logic        [VOICE_W-1:0]    out_voice_out
);

  localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VEXT_W  = 7;
  localparam int MULI_W  = PHASE_W + GAIN_W;
  localparam int P1_W    = SAMPLE_W + GAIN_W + 1;
  localparam int P2_W    = P1_W + GAIN_W + 1;
  localparam int SH      = 28;
  localparam int SHV_W   = P2_W - SH;

  // Configuration registers
  logic              sync_r;
  logic [GAIN_W-1:0] ratio_r;
  logic [GAIN_W-1:0] gain_r;
  logic [GAIN_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r  <= 1'b0;
      ratio_r <= RATIO_RESET;
      gain_r  <= '0;
      scale_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_SYNC_ENABLE: sync_r  <= cfg_data[0];
        CFG_FREQ_RATIO:  ratio_r <= cfg_data;
        CFG_DEPTH_GAIN:  gain_r  <= cfg_data;
        CFG_DEPTH_SCALE: scale_r <= cfg_data;
      endcase
    end
  end

  // Decode the input word
  logic [VEXT_W-1:0] voice_ext;
  assign voice_ext       = VEXT_W'(in_voice);
  assign status.step_req = (in_opcode == OP_STEP) && (voice_ext < VEXT_W'(VOICES));
  assign status.tbl_req  = (in_opcode == OP_TWR);

  // Scale the increment; only its low bits survive the phase wrap
  logic [MULI_W-1:0]  inc_mult;
  logic [PHASE_W-1:0] inc_nxt;
  assign inc_mult = MULI_W'(in_increment) * MULI_W'(ratio_r);
  assign inc_nxt  = sync_r ? inc_mult[RATIO_SH +: PHASE_W] : in_increment;

  logic [PHASE_W-1:0] inc_r;
  logic [VOICE_W-1:0] voice_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      inc_r   <= inc_nxt;
      voice_r <= in_voice;
    end
  end

  // Phase accumulators, wrap is the natural overflow of the 10.16 word
  logic [PHASE_W-1:0] phase_r [VOICES];
  logic [VIDX_W-1:0]  vidx;
  logic [VEXT_W-1:0]  voice_r_ext;
  logic [PHASE_W-1:0] phase_new;

  assign voice_r_ext = VEXT_W'(voice_r);
  assign vidx        = voice_r_ext[VIDX_W-1:0];
  assign phase_new   = phase_r[vidx] + inc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        phase_r[i] <= '0;
      end
    end else if (cmd.phase_upd) begin
      phase_r[vidx] <= phase_new;
    end
  end

  // Wavetable: every 10-bit address is in range
  logic signed [SAMPLE_W-1:0] table_mem [TABLE_SIZE];
  logic signed [SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr) begin
      table_mem[in_table_addr] <= in_table_data;
    end
    if (cmd.phase_upd) begin
      rd_data_r <= table_mem[phase_new[FRAC_W +: TBL_AW]];
    end
  end

  // Apply both gains, one multiply per cycle
  logic signed [P1_W-1:0] prod1_r;
  logic signed [P2_W-1:0] prod2_r;

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod1_r <= P1_W'(rd_data_r) * P1_W'($signed({1'b0, gain_r}));
    end
    if (cmd.mul2) begin
      prod2_r <= P2_W'(prod1_r) * P2_W'($signed({1'b0, scale_r}));
    end
  end

  // Floor shift and saturate
  logic signed [SHV_W-1:0]    shv;
  logic signed [SAMPLE_W-1:0] sat;
  assign shv = prod2_r[P2_W-1:SH];

  always_comb begin
    priority if (shv > SHV_W'(32767)) begin
      sat = 16'sh7FFF;
    end else if (shv < -SHV_W'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = shv[SAMPLE_W-1:0];
    end
  end

  // Output register, freed when the word is taken
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic        [VOICE_W-1:0]  voice_out_r;
  logic                       out_take;

  assign out_take        = out_valid_r && !out_stall;
  assign status.out_full = out_valid_r && !out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sample_r    <= sat;
      voice_out_r <= voice_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = sample_r;
  assign out_voice_out = voice_out_r;

endmodule

// ===== rtl/multi_voice_pm_wavetable_oscillator_core.sv =====
// A step word runs phase update and table read, two gain multiplies and the output load in
// sequence on one datapath; no new input word is taken until its result is loaded, and the
// load waits for a free output register. A table write word leaves the input open.
// The output register holds a finished word while the next input word is taken.
// Reset (synchronous, active low) clears phases, state, output valid and registers
// to their defaults; the wavetable is left as is.
module multi_voice_pm_wavetable_oscillator_core
  import mvpmwo_pkg::*;
#(
  parameter int VOICES = VOICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic        [VOICE_W-1:0]    in_voice,
  input  logic        [PHASE_W-1:0]    in_increment,
  input  logic        [TBL_AW-1:0]     in_table_addr,
  input  logic signed [SAMPLE_W-1:0]   in_table_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [SAMPLE_W-1:0]   out_sample,
  output logic        [VOICE_W-1:0]    out_voice_out,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  // Registers accept a word in any cycle
  assign cfg_ready = 1'b1;

  mvpmwo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mvpmwo_dp #(
    .VOICES (VOICES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_opcode     (in_opcode),
    .in_voice      (in_voice),
    .in_increment  (in_increment),
    .in_table_addr (in_table_addr),
    .in_table_data (in_table_data),
    .cfg_wr        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample    (out_sample),
    .out_voice_out (out_voice_out)
  );

endmodule

// ===== rtl/mvpmwo_chk.sv =====
module mvpmwo_chk
  import mvpmwo_pkg::*;
#(
  parameter int VOICES = VOICES_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       in_opcode,
  input logic [VOICE_W-1:0]         in_voice,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [SAMPLE_W-1:0] out_sample,
  input logic [VOICE_W-1:0]         out_voice_out
);

  logic step_acc;
  logic twr_acc;
  assign step_acc = in_valid && !in_stall && (in_opcode == OP_STEP) &&
                    (int'(in_voice) < VOICES);
  assign twr_acc  = in_valid && !in_stall && (in_opcode == OP_TWR);

  // A step word blocks the input while it is worked on
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step_acc |=> in_stall)
    else $error("input not stalled after a step word");

  // A table write leaves the input open
  a_twr_free: assert property (@(posedge clk) disable iff (!rst_n)
    twr_acc |=> !in_stall)
    else $error("input stalled after a table write");

  // Results only name voices that exist
  a_voice_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_voice_out) < VOICES))
    else $error("result for a voice out of range");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample) &&
                               $stable(out_voice_out))
    else $error("stalled result changed");

  // Drop the result on reset
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multi_voice_pm_wavetable_oscillator_core mvpmwo_chk #(
  .VOICES (VOICES)
) u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_opcode     (in_opcode),
  .in_voice      (in_voice),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_sample    (out_sample),
  .out_voice_out (out_voice_out)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
  import mvpmwo_pkg::*;
();

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic        [VOICE_W-1:0]  voice;
  } sample_word_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_opcode;
  logic        [VOICE_W-1:0]    in_voice;
  logic        [PHASE_W-1:0]    in_increment;
  logic        [TBL_AW-1:0]     in_table_addr;
  logic signed [SAMPLE_W-1:0]   in_table_data;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [SAMPLE_W-1:0]   out_sample;
  logic        [VOICE_W-1:0]    out_voice_out;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic        [CFG_IDX_W-1:0]  cfg_index;
  logic        [CFG_DATA_W-1:0] cfg_data;

  // Oscillator state as the testbench sees it
  logic        [PHASE_W-1:0]  phase_acc [VOICES_DEF];
  logic signed [SAMPLE_W-1:0] wave_mem  [TABLE_SIZE];
  logic                       sync_on;
  logic        [GAIN_W-1:0]   ratio_q;
  logic        [GAIN_W-1:0]   gain_a;
  logic        [GAIN_W-1:0]   gain_b;

  sample_word_t pending_samples [$];
  int           error_count = 0;
  logic         idle_off    = 1'b0;
  int           stall_left  = 0;

  always #5 clk = ~clk;

  multi_voice_pm_wavetable_oscillator_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_voice      (in_voice),
    .in_increment  (in_increment),
    .in_table_addr (in_table_addr),
    .in_table_data (in_table_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample    (out_sample),
    .out_voice_out (out_voice_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Advance one voice and compute the scaled, saturated sample it produces
  function automatic sample_word_t advance_voice(logic [VOICE_W-1:0] v,
                                                 logic [PHASE_W-1:0] inc);
    logic        [41:0]         wide;
    logic        [PHASE_W-1:0]  step_amt;
    logic        [PHASE_W-1:0]  ph;
    logic signed [SAMPLE_W-1:0] entry;
    longint                     prod;
    longint                     scaled;
    sample_word_t               w;
    if (sync_on) begin
      wide     = 42'(inc) * 42'(ratio_q);
      step_amt = wide[RATIO_SH +: PHASE_W];
    end else begin
      step_amt = inc;
    end
    // phase wraps at 2^26, which is the table size in 10.16
    ph           = phase_acc[v] + step_amt;
    phase_acc[v] = ph;
    entry        = wave_mem[ph[PHASE_W-1:FRAC_W]];
    prod         = longint'(entry) * longint'(gain_a) * longint'(gain_b);
    scaled       = prod >>> 28;
    if (scaled > 32767) begin
      scaled = 32767;
    end else if (scaled < -32768) begin
      scaled = -32768;
    end
    w.sample = scaled[SAMPLE_W-1:0];
    w.voice  = v;
    return w;
  endfunction

  // Increments: mostly full range, some small, some at the top
  function automatic logic [PHASE_W-1:0] rand_increment();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: return PHASE_W'($urandom_range(0, 8 << FRAC_W));
      1: return {PHASE_W{1'b1}};
      default: return r[PHASE_W-1:0];
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return {GAIN_W{1'b1}};
      2: return 16'd16384;
      3: return GAIN_W'($urandom_range(0, 20000));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // Present one input word and hold it until taken, then update the state
  task automatic send_word(logic op, logic [VOICE_W-1:0] v, logic [PHASE_W-1:0] inc,
                           logic [TBL_AW-1:0] addr, logic signed [SAMPLE_W-1:0] data);
    int gap;
    if (!idle_off && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_voice      <= v;
    in_increment  <= inc;
    in_table_addr <= addr;
    in_table_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_TWR) begin
      wave_mem[addr] = data;
    end else begin
      pending_samples.push_back(advance_voice(v, inc));
    end
  endtask

  task automatic step_voice(logic [VOICE_W-1:0] v, logic [PHASE_W-1:0] inc);
    send_word(OP_STEP, v, inc, TBL_AW'($urandom), SAMPLE_W'($urandom));
  endtask

  task automatic write_entry(logic [TBL_AW-1:0] addr, logic signed [SAMPLE_W-1:0] data);
    send_word(OP_TWR, VOICE_W'($urandom), rand_increment(), addr, data);
  endtask

  // Hold the input idle until every expected word is back, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SYNC_ENABLE: sync_on = data[0];
      CFG_FREQ_RATIO:  ratio_q = data;
      CFG_DEPTH_GAIN:  gain_a  = data;
      CFG_DEPTH_SCALE: gain_b  = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Load every table entry so no step can read an unwritten one
  task automatic test_table_fill();
    for (int a = 0; a < TABLE_SIZE; a++) begin
      if (a == 0) begin
        write_entry(TBL_AW'(a), -16'sd32768);
      end else if (a == TABLE_SIZE - 1) begin
        write_entry(TBL_AW'(a), 16'sd32767);
      end else begin
        write_entry(TBL_AW'(a), SAMPLE_W'($urandom));
      end
    end
  endtask

  // Register defaults: zero gains give silence, phases start at zero
  task automatic test_reset_defaults();
    step_voice(3'd0, 26'd0);
    step_voice(3'd3, 26'h3FFFFFF);
    step_voice(3'd7, 26'h0123456);
    step_voice(3'd3, 26'd1);
    drain_results();
  endtask

  // Unity and maximum gains, table extremes, wrap, write then read
  task automatic test_directed_gains();
    write_reg(CFG_DEPTH_GAIN, 16'd16384);
    write_reg(CFG_DEPTH_SCALE, 16'd16384);
    step_voice(3'd0, 26'd0);
    step_voice(3'd7, 26'h3FFFFFF);
    step_voice(3'd7, 26'd1);
    step_voice(3'd1, 26'd1 << FRAC_W);
    write_entry(10'd1, 16'sd12345);
    step_voice(3'd1, 26'd0);
    write_entry(10'd2, 16'sd1);
    write_entry(10'd3, -16'sd1);
    drain_results();
    write_reg(CFG_DEPTH_GAIN, 16'hFFFF);
    write_reg(CFG_DEPTH_SCALE, 16'hFFFF);
    step_voice(3'd0, 26'd0);
    step_voice(3'd6, 26'h3FFFFFF);
    step_voice(3'd2, 26'd2 << FRAC_W);
    step_voice(3'd3, 26'd3 << FRAC_W);
    drain_results();
  endtask

  // Sync on with zero, maximum and identity ratios
  task automatic test_directed_sync();
    write_reg(CFG_DEPTH_GAIN, 16'd16384);
    write_reg(CFG_DEPTH_SCALE, 16'd16384);
    write_reg(CFG_SYNC_ENABLE, 16'd1);
    write_reg(CFG_FREQ_RATIO, 16'd0);
    step_voice(3'd4, 26'h3FFFFFF);
    drain_results();
    write_reg(CFG_FREQ_RATIO, 16'hFFFF);
    step_voice(3'd5, 26'h3FFFFFF);
    step_voice(3'd5, 26'h3FFFFFF);
    drain_results();
    write_reg(CFG_FREQ_RATIO, RATIO_RESET);
    step_voice(3'd6, 26'd5 << FRAC_W);
    drain_results();
  endtask

  // Random settings per phase, random mix of steps and table writes
  task automatic test_random_phases();
    logic [CFG_DATA_W-1:0] ratio_val;
    for (int p = 0; p < 6; p++) begin
      if (p == 5) idle_off = 1'b1;
      case ($urandom_range(0, 3))
        0: ratio_val = '0;
        1: ratio_val = {CFG_DATA_W{1'b1}};
        2: ratio_val = RATIO_RESET;
        default: ratio_val = CFG_DATA_W'($urandom);
      endcase
      write_reg(CFG_FREQ_RATIO, ratio_val);
      write_reg(CFG_SYNC_ENABLE, CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(CFG_DEPTH_GAIN, pick_gain());
      write_reg(CFG_DEPTH_SCALE, pick_gain());
      for (int n = 0; n < 150; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          write_entry(TBL_AW'($urandom), SAMPLE_W'($urandom));
        end else begin
          step_voice(VOICE_W'($urandom), rand_increment());
        end
      end
      drain_results();
    end
  endtask

  // Stall the result side in short random bursts
  always @(posedge clk) begin
    if (idle_off) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each taken result word with the oldest expectation
  always @(posedge clk) begin
    sample_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected result word: sample %0d voice_out %0d", out_sample, out_voice_out);
        error_count++;
      end else begin
        exp_w = pending_samples.pop_front();
        if (out_sample !== exp_w.sample) begin
          $error("sample mismatch: expected %0d, actual %0d", exp_w.sample, out_sample);
          error_count++;
        end
        if (out_voice_out !== exp_w.voice) begin
          $error("voice_out mismatch: expected %0d, actual %0d", exp_w.voice, out_voice_out);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_opcode     <= OP_STEP;
    in_voice      <= '0;
    in_increment  <= '0;
    in_table_addr <= '0;
    in_table_data <= '0;
    out_stall     <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_SYNC_ENABLE;
    cfg_data      <= '0;
    for (int v = 0; v < VOICES_DEF; v++) phase_acc[v] = '0;
    sync_on = 1'b0;
    ratio_q = RATIO_RESET;
    gain_a  = '0;
    gain_b  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_fill();
    test_reset_defaults();
    test_directed_gains();
    test_directed_sync();
    test_random_phases();

    drain_results();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #4_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ===== multi_voice_pm_wavetable_oscillator_core.f =====
rtl/mvpmwo_pkg.sv
rtl/mvpmwo_ctrl.sv
rtl/mvpmwo_dp.sv
rtl/multi_voice_pm_wavetable_oscillator_core.sv
rtl/mvpmwo_chk.sv
verif/tb_top.sv
